// ===== hw/rtl/rvn_pkg.sv =====
package rvn_pkg;

  localparam int unsigned ChW = 8;
  localparam int unsigned NumCh = 3;
  localparam int unsigned SqW = 16;
  // sum of three squares
  localparam int unsigned SumW = 18;
  // wide enough for (2q-1)^2 * s and (510*c)^2 with margin
  localparam int unsigned AccW = 40;
  // 510 squared: scale of the right-hand side
  localparam logic [AccW-1:0] RhsScale = AccW'(260100);
  localparam logic [ChW-1:0] AlphaOpaque = 8'hFF;
  // one register stage per result bit
  localparam int unsigned NumBitStages = ChW;

  typedef struct packed {
    logic [ChW-1:0] red_in;
    logic [ChW-1:0] green_in;
    logic [ChW-1:0] blue_in;
    logic           last_pixel_in;
  } pix_in_t;

  typedef struct packed {
    logic [ChW-1:0] red_out;
    logic [ChW-1:0] green_out;
    logic [ChW-1:0] blue_out;
    logic [ChW-1:0] alpha_out;
    logic           last_pixel_out;
  } pix_out_t;

endpackage

// ===== hw/rtl/rgb_vector_normalizer.sv =====
// rgb pixel normalizer: scales (r,g,b) to unit length, 255*c/|v| rounded to nearest
// pipeline: 10 register stages (squares, sums, 8 result bits)
// throughput: one pixel per cycle while out_stall_i is low, every stage then takes a new pixel each cycle
// a stall holds the full stages; bubbles are squeezed out of the pipeline
// reset: asynchronous active low, clears all valid bits; data registers are not reset
module rgb_vector_normalizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rvn_pkg::pix_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rvn_pkg::pix_out_t  out_data_o
);
  import rvn_pkg::*;

  localparam int unsigned NumStg = NumBitStages + 1;

  // first stage: channel squares
  logic                v0_q;
  logic [SqW-1:0]      sq_q [NumCh];
  logic                last0_q;

  // search stages, index 0 holds sum and right-hand sides
  logic                v_q    [NumStg];
  logic [AccW-1:0]     a_q    [NumStg][NumCh];
  logic [AccW-1:0]     b_q    [NumStg][NumCh];
  logic [AccW-1:0]     n_q    [NumStg][NumCh];
  logic [ChW-1:0]      res_q  [NumStg][NumCh];
  logic [SumW-1:0]     s_q    [NumStg];
  logic                last_q [NumStg];

  logic                en0;
  logic                en     [NumStg];
  logic [ChW-1:0]      in_ch  [NumCh];
  logic [SumW-1:0]     sum_d;

  assign in_ch[0] = in_data_i.red_in;
  assign in_ch[1] = in_data_i.green_in;
  assign in_ch[2] = in_data_i.blue_in;

  // stage enables, a stage moves when empty or when its successor moves
  assign en[NumStg-1] = !v_q[NumStg-1] || !out_stall_i;
  for (genvar j = 0; j < NumStg - 1; j++) begin : g_en
    assign en[j] = !v_q[j] || en[j+1];
  end
  assign en0 = !v0_q || en[0];
  assign in_stall_o = !en0;

  // squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      for (int i = 0; i < NumCh; i++) begin
        sq_q[i] <= in_ch[i] * in_ch[i];
      end
      last0_q <= in_data_i.last_pixel_in;
    end
  end

  // sum of squares and scaled right-hand sides
  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && v0_q) begin
      for (int i = 0; i < NumCh; i++) begin
        n_q[0][i]   <= AccW'(sq_q[i]) * RhsScale;
        a_q[0][i]   <= '0;
        b_q[0][i]   <= '0;
        res_q[0][i] <= '0;
      end
      s_q[0]    <= sum_d;
      last_q[0] <= last0_q;
    end
  end

  // one result bit per stage, msb first; with u = 2q keep a = u*u*s and b = u*s
  for (genvar j = 0; j < NumBitStages; j++) begin : g_bit
    localparam int unsigned K = NumBitStages - 1 - j;

    logic [AccW-1:0] s_ext;
    logic [AccW-1:0] a_try [NumCh];
    logic [AccW-1:0] b_try [NumCh];
    logic [AccW-1:0] t_try [NumCh];
    logic            take  [NumCh];

    assign s_ext = AccW'(s_q[j]);

    always_comb begin
      for (int i = 0; i < NumCh; i++) begin
        a_try[i] = a_q[j][i] + (b_q[j][i] << (K + 2)) + (s_ext << (2 * K + 2));
        b_try[i] = b_q[j][i] + (s_ext << (K + 1));
        t_try[i] = a_try[i] - (b_try[i] << 1) + s_ext;
        take[i]  = (t_try[i] <= n_q[j][i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en[j+1]) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j+1] && v_q[j]) begin
        for (int i = 0; i < NumCh; i++) begin
          n_q[j+1][i] <= n_q[j][i];
          if (take[i]) begin
            a_q[j+1][i]   <= a_try[i];
            b_q[j+1][i]   <= b_try[i];
            res_q[j+1][i] <= res_q[j][i] | (ChW'(1) << K);
          end else begin
            a_q[j+1][i]   <= a_q[j][i];
            b_q[j+1][i]   <= b_q[j][i];
            res_q[j+1][i] <= res_q[j][i];
          end
        end
        s_q[j+1]    <= s_q[j];
        last_q[j+1] <= last_q[j];
      end
    end
  end

  // output, black pixel gives black
  logic blk;
  assign blk = (s_q[NumStg-1] == '0);

  assign out_valid_o               = v_q[NumStg-1];
  assign out_data_o.red_out        = blk ? '0 : res_q[NumStg-1][0];
  assign out_data_o.green_out      = blk ? '0 : res_q[NumStg-1][1];
  assign out_data_o.blue_out       = blk ? '0 : res_q[NumStg-1][2];
  assign out_data_o.alpha_out      = AlphaOpaque;
  assign out_data_o.last_pixel_out = last_q[NumStg-1];

endmodule
